// ----- hdl/ipraf_pkg.sv -----
// shared types, constants and codes of the address range and country allow filter
package ipraf_pkg;

   localparam int MAX_RANGES    = 64;
   localparam int COUNTRY_COUNT = 256;

   localparam int RANGE_ADDR_W = $clog2(MAX_RANGES);
   localparam int RANGE_CNT_W  = 7;
   localparam int CTRY_IDX_W   = $clog2(COUNTRY_COUNT);
   localparam int RANGE_DATA_W = 64;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RANGE_COUNT   = 1'd1;

   localparam logic [2:0] RSN_DISABLED     = 3'd0;
   localparam logic [2:0] RSN_UNASSIGNED   = 3'd1;
   localparam logic [2:0] RSN_RANGE_HIT    = 3'd2;
   localparam logic [2:0] RSN_CTRY_ALLOWED = 3'd3;
   localparam logic [2:0] RSN_CTRY_BLOCKED = 3'd4;
   localparam logic [2:0] RSN_CTRY_UNKNOWN = 3'd5;

   typedef enum logic [1:0] {
      OP_CHECK = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2,
      OP_ALLOW = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] ip_address;
      logic [5:0]  range_index;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [15:0] country_code;
   } req_type;

   typedef struct packed {
      logic       allowed;
      logic [2:0] decision_reason;
   } rsp_type;

   typedef struct packed {
      op_type      op;
      logic        in_table;
      logic [31:0] ip_address;
      logic [5:0]  range_index;
      logic [31:0] range_low;
      logic [31:0] range_high;
      logic [15:0] country_code;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef struct packed {
      logic                   filter_enable;
      logic [RANGE_CNT_W-1:0] range_count;
   } cfg_type;

endpackage

// ----- hdl/ipraf_ram.sv -----
// generic single write port ram with registered read
module ipraf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ipraf_front.sv -----
// input stage: accepts items, classifies them and queues them for the back end
module ipraf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  ipraf_pkg::req_type       req_data,
   output ipraf_pkg::queue_out_type q_out,
   input  logic                     pop
);

   ipraf_pkg::cmd_type cmd_ff [ipraf_pkg::Q_DEPTH];
   ipraf_pkg::cmd_type cmd_new;

   logic [ipraf_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ipraf_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ipraf_pkg::Q_CNT_W-1:0] count_ff, count_in;
   logic                          push;
   logic                          do_pop;

   // classify
   always_comb begin
      cmd_new.op           = ipraf_pkg::op_type'(req_data.kind);
      cmd_new.ip_address   = req_data.ip_address;
      cmd_new.range_index  = req_data.range_index;
      cmd_new.range_low    = req_data.range_low;
      cmd_new.range_high   = req_data.range_high;
      cmd_new.country_code = req_data.country_code;
      if (cmd_new.op == ipraf_pkg::OP_WRITE) begin
         cmd_new.in_table = 32'(req_data.range_index) < ipraf_pkg::MAX_RANGES;
      end else begin
         cmd_new.in_table = 32'(req_data.country_code) < ipraf_pkg::COUNTRY_COUNT;
      end
   end

   assign req_ready = count_ff != ipraf_pkg::Q_CNT_W'(ipraf_pkg::Q_DEPTH);
   assign push      = req_valid && req_ready;
   assign do_pop    = pop && q_out.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ipraf_pkg::Q_PTR_W'(ipraf_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ipraf_pkg::Q_PTR_W'(ipraf_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign q_out.valid = count_ff != '0;
   assign q_out.cmd   = cmd_ff[rd_ptr_ff];

endmodule

// ----- hdl/ipraf_back.sv -----
// execution stage: table updates, range walk, decision and result register
module ipraf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ipraf_pkg::queue_out_type q_in,
   output logic                     pop,
   input  ipraf_pkg::cfg_type       cfg,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ipraf_pkg::rsp_type       rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_EMIT   = 5'b01000,
      ST_CLEAR  = 5'b10000
   } state_type;

   state_type                                state_ff, state_in;
   logic [ipraf_pkg::RANGE_CNT_W-1:0]        idx_ff, idx_in, idx_next;
   logic [ipraf_pkg::RANGE_CNT_W-1:0]        used;
   logic [31:0]                              addr_ff, addr_in;
   logic                                     ctry_ok_ff, ctry_ok_in;
   logic [ipraf_pkg::CTRY_IDX_W-1:0]         ctry_idx_ff, ctry_idx_in;
   logic [ipraf_pkg::CTRY_IDX_W-1:0]         clr_idx_ff, clr_idx_in;
   ipraf_pkg::rsp_type                       res_ff, res_in, ctry_res;
   logic                                     rsp_valid_ff, rsp_valid_in;
   ipraf_pkg::rsp_type                       rsp_ff;
   logic                                     out_free;
   logic                                     ram_we;
   logic [ipraf_pkg::RANGE_ADDR_W-1:0]       ram_rd_addr;
   logic [ipraf_pkg::RANGE_DATA_W-1:0]       ram_rd_data;
   logic                                     hit;
   logic                                     ctry_we;
   logic [ipraf_pkg::CTRY_IDX_W-1:0]         ctry_wr_addr;
   logic                                     ctry_wr_data;
   logic [ipraf_pkg::CTRY_IDX_W-1:0]         ctry_rd_addr;
   logic                                     ctry_rd_data;

   assign used = (32'(cfg.range_count) > ipraf_pkg::MAX_RANGES) ?
                 ipraf_pkg::RANGE_CNT_W'(ipraf_pkg::MAX_RANGES) : cfg.range_count;

   assign idx_next = idx_ff + 1'b1;
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign ram_we = (state_ff == ST_IDLE) && q_in.valid &&
                   (q_in.cmd.op == ipraf_pkg::OP_WRITE) && q_in.cmd.in_table;
   assign ram_rd_addr = (state_ff == ST_SCAN) ?
                        idx_next[ipraf_pkg::RANGE_ADDR_W-1:0] : '0;

   ipraf_ram #(
      .WIDTH (ipraf_pkg::RANGE_DATA_W),
      .DEPTH (ipraf_pkg::MAX_RANGES)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (q_in.cmd.range_index[ipraf_pkg::RANGE_ADDR_W-1:0]),
      .wr_data ({q_in.cmd.range_low, q_in.cmd.range_high}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign hit = (addr_ff >= ram_rd_data[63:32]) && (addr_ff <= ram_rd_data[31:0]);

   // country map: cleared one entry a cycle, looked up at the check's country
   assign ctry_we      = (state_ff == ST_CLEAR) ||
                         ((state_ff == ST_IDLE) && q_in.valid &&
                          (q_in.cmd.op == ipraf_pkg::OP_ALLOW) && q_in.cmd.in_table);
   assign ctry_wr_addr = (state_ff == ST_CLEAR) ? clr_idx_ff :
                         q_in.cmd.country_code[ipraf_pkg::CTRY_IDX_W-1:0];
   assign ctry_wr_data = (state_ff != ST_CLEAR);
   assign ctry_rd_addr = (state_ff == ST_IDLE) ?
                         q_in.cmd.country_code[ipraf_pkg::CTRY_IDX_W-1:0] : ctry_idx_ff;

   ipraf_ram #(
      .WIDTH (1),
      .DEPTH (ipraf_pkg::COUNTRY_COUNT)
   ) u_country_ram (
      .clock   (clock),
      .wr_en   (ctry_we),
      .wr_addr (ctry_wr_addr),
      .wr_data (ctry_wr_data),
      .rd_addr (ctry_rd_addr),
      .rd_data (ctry_rd_data)
   );

   always_comb begin
      if (!ctry_ok_ff) begin
         ctry_res.allowed         = 1'b0;
         ctry_res.decision_reason = ipraf_pkg::RSN_CTRY_UNKNOWN;
      end else if (ctry_rd_data) begin
         ctry_res.allowed         = 1'b1;
         ctry_res.decision_reason = ipraf_pkg::RSN_CTRY_ALLOWED;
      end else begin
         ctry_res.allowed         = 1'b0;
         ctry_res.decision_reason = ipraf_pkg::RSN_CTRY_BLOCKED;
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      addr_in      = addr_ff;
      ctry_ok_in   = ctry_ok_ff;
      ctry_idx_in  = ctry_idx_ff;
      clr_idx_in   = clr_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_in.valid) begin
               pop = 1'b1;
               unique case (q_in.cmd.op)
                  ipraf_pkg::OP_CHECK: begin
                     addr_in     = q_in.cmd.ip_address;
                     ctry_ok_in  = q_in.cmd.in_table;
                     ctry_idx_in = q_in.cmd.country_code[ipraf_pkg::CTRY_IDX_W-1:0];
                     idx_in      = '0;
                     if (!cfg.filter_enable) begin
                        res_in.allowed         = 1'b1;
                        res_in.decision_reason = ipraf_pkg::RSN_DISABLED;
                        state_in               = ST_EMIT;
                     end else if (q_in.cmd.country_code == '0) begin
                        res_in.allowed         = 1'b1;
                        res_in.decision_reason = ipraf_pkg::RSN_UNASSIGNED;
                        state_in               = ST_EMIT;
                     end else if (used == '0) begin
                        state_in = ST_DECIDE;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ipraf_pkg::OP_CLEAR: begin
                     clr_idx_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  ipraf_pkg::OP_ALLOW: begin
                  end
                  ipraf_pkg::OP_WRITE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.allowed         = 1'b1;
               res_in.decision_reason = ipraf_pkg::RSN_RANGE_HIT;
               state_in               = ST_EMIT;
            end else if (idx_next == used) begin
               res_in   = ctry_res;
               state_in = ST_EMIT;
            end else begin
               idx_in = idx_next;
            end
         end
         ST_DECIDE: begin
            res_in   = ctry_res;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            if (clr_idx_ff == ipraf_pkg::CTRY_IDX_W'(ipraf_pkg::COUNTRY_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      addr_ff     <= addr_in;
      ctry_ok_ff  <= ctry_ok_in;
      ctry_idx_ff <= ctry_idx_in;
      res_ff      <= res_in;
      if ((state_ff == ST_EMIT) && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_scan_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff < used))
      else $error("range walk beyond used entries");

   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == ST_IDLE) && q_in.valid)
      else $error("queue popped while busy");

   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && out_free |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("result not moved to output");

   a_block_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.allowed |->
         (rsp_ff.decision_reason == ipraf_pkg::RSN_CTRY_BLOCKED) ||
         (rsp_ff.decision_reason == ipraf_pkg::RSN_CTRY_UNKNOWN))
      else $error("blocked item with an admitting reason");

endmodule

// ----- hdl/ip_range_and_country_allow_filter.sv -----
// top level of the IPv4 address range and country allow filter
//
// req channel (valid/ready): kind 0 checks an address and gives one rsp item;
// kind 1 writes a range entry, kind 2 clears the country map, kind 3 allows a
// country; load items give no rsp item. Up to two items wait in a queue ahead
// of the execution stage, so req takes two more items while a check is busy.
// A range write or a country allow is done in the execution stage as it
// leaves the queue; a clear walks the country map ram one entry a cycle.
// A check goes straight to its output step when the filter is off or the
// country is unassigned, through a decide step when the country map alone
// settles it, else walks the used range entries to the first hit (at most
// range_count, capped at 64), one entry a cycle on the single range ram port.
// rsp channel (valid/ready): a held result stalls the next check at its output
// step, and the execution stage with it; until then loads and queueing go on.
// csr port: csr_we writes filter_enable (index 0) or range_count (index 1);
// the user must do so only while the block is idle: the block does not enforce
// it. Reset clears both registers, the queue and the rsp valid flag, then
// clears the country map before the first item leaves the queue; range entries
// hold garbage until written.
module ip_range_and_country_allow_filter (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  ipraf_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output ipraf_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [ipraf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ipraf_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ipraf_pkg::cfg_type       cfg_ff, cfg_in;
   ipraf_pkg::queue_out_type q_head;
   logic                     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ipraf_pkg::CSR_FILTER_ENABLE: cfg_in.filter_enable = csr_wdata[0];
            ipraf_pkg::CSR_RANGE_COUNT: begin
               cfg_in.range_count = csr_wdata[ipraf_pkg::RANGE_CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipraf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_out     (q_head),
      .pop       (pop)
   );

   ipraf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_in      (q_head),
      .pop       (pop),
      .cfg       (cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/ip_range_and_country_allow_filter_checker.sv -----
// checker for the address range and country allow filter: predicts each decision and compares rsp items
module ip_range_and_country_allow_filter_checker
   import ipraf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     verdicts_pending,
   output int                     mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0]            span_first [MAX_RANGES];
   logic [31:0]            span_last [MAX_RANGES];
   logic                   country_ok [COUNTRY_COUNT];
   logic                   enabled;
   logic [RANGE_CNT_W-1:0] spans_used;
   rsp_type                verdicts_due [$];

   initial begin
      verdicts_pending = 0;
      mismatch_count = 0;
   end

   function automatic rsp_type admission_verdict(req_type item);
      rsp_type verdict;
      int      limit;
      bit      hit;
      limit = (spans_used > MAX_RANGES) ? MAX_RANGES : int'(spans_used);
      hit = 1'b0;
      for (int i = 0; i < limit; i++)
         if (item.ip_address >= span_first[i] && item.ip_address <= span_last[i])
            hit = 1'b1;
      if (!enabled)
         verdict = '{allowed: 1'b1, decision_reason: RSN_DISABLED};
      else if (item.country_code == 16'd0)
         verdict = '{allowed: 1'b1, decision_reason: RSN_UNASSIGNED};
      else if (hit)
         verdict = '{allowed: 1'b1, decision_reason: RSN_RANGE_HIT};
      else if (item.country_code >= COUNTRY_COUNT)
         verdict = '{allowed: 1'b0, decision_reason: RSN_CTRY_UNKNOWN};
      else if (country_ok[item.country_code[CTRY_IDX_W-1:0]])
         verdict = '{allowed: 1'b1, decision_reason: RSN_CTRY_ALLOWED};
      else
         verdict = '{allowed: 1'b0, decision_reason: RSN_CTRY_BLOCKED};
      return verdict;
   endfunction

   function automatic void flag_mismatch(string text);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", text);
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         enabled = 1'b0;
         spans_used = '0;
         foreach (country_ok[c])
            country_ok[c] = 1'b0;
         verdicts_due.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_FILTER_ENABLE)
               enabled = csr_wdata[0];
            else if (csr_index == CSR_RANGE_COUNT)
               spans_used = csr_wdata[RANGE_CNT_W-1:0];
         end
         if (req_valid && req_ready) begin
            case (op_type'(req_data.kind))
               OP_CHECK: verdicts_due.push_back(admission_verdict(req_data));
               OP_WRITE: begin
                  if (req_data.range_index < MAX_RANGES) begin
                     span_first[req_data.range_index] = req_data.range_low;
                     span_last[req_data.range_index] = req_data.range_high;
                  end
               end
               OP_CLEAR: begin
                  foreach (country_ok[c])
                     country_ok[c] = 1'b0;
               end
               OP_ALLOW: begin
                  if (req_data.country_code < COUNTRY_COUNT)
                     country_ok[req_data.country_code[CTRY_IDX_W-1:0]] = 1'b1;
               end
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               flag_mismatch($sformatf("mismatch: rsp item with no check waiting, allowed=%0d reason=%0d",
                                       rsp_data.allowed, rsp_data.decision_reason));
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_data.allowed !== want.allowed ||
                   rsp_data.decision_reason !== want.decision_reason)
                  flag_mismatch($sformatf("mismatch: expected allowed=%0d reason=%0d, got allowed=%0d reason=%0d",
                                          want.allowed, want.decision_reason,
                                          rsp_data.allowed, rsp_data.decision_reason));
            end
         end
      end
      verdicts_pending = verdicts_due.size();
   end

endmodule

// ----- verif/ip_range_and_country_allow_filter_test.sv -----
// testbench top for the address range and country allow filter: stimulus, idling and verdict
module ip_range_and_country_allow_filter_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ipraf_pkg::*;

   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 800;
   localparam int PHASE_ITEMS   = 220;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   int                     verdicts_pending;
   int                     mismatch_count;
   int                     quiet_cycles = 0;
   bit                     hold_rsp = 1'b0;
   bit                     burst_mode = 1'b0;
   int                     cur_count = 0;
   logic [31:0]            span_lo [MAX_RANGES];
   logic [31:0]            span_hi [MAX_RANGES];

   ip_range_and_country_allow_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ip_range_and_country_allow_filter_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .verdicts_pending (verdicts_pending),
      .mismatch_count   (mismatch_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_side
      int gap;
      int taken;
      bit held;
      taken = 0;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            held = 1'b1;
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         gap = ((taken / 50) % 3 != 0) ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            rsp_ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   function automatic req_type compose(op_type op, logic [31:0] ip, logic [5:0] idx,
                                       logic [31:0] lo, logic [31:0] hi, logic [15:0] cc);
      req_type item;
      item.kind = op;
      item.ip_address = ip;
      item.range_index = idx;
      item.range_low = lo;
      item.range_high = hi;
      item.country_code = cc;
      return item;
   endfunction

   function automatic req_type random_item(int pick);
      req_type item;
      int      cap;
      int      j;
      item.kind = 2'($urandom_range(0, 3));
      item.ip_address = $urandom();
      item.range_index = 6'($urandom_range(0, 63));
      item.range_low = $urandom();
      item.range_high = $urandom();
      item.country_code = 16'($urandom_range(0, 65535));
      cap = (cur_count > MAX_RANGES) ? MAX_RANGES : cur_count;
      j = (cap > 0) ? $urandom_range(0, cap - 1) : $urandom_range(0, MAX_RANGES - 1);
      if (pick < 55) begin
         item.kind = OP_CHECK;
         case ($urandom_range(0, 7))
            0: item.ip_address = span_lo[j];
            1: item.ip_address = span_hi[j];
            2: item.ip_address = span_lo[j] - 32'd1;
            3: item.ip_address = span_hi[j] + 32'd1;
            4: item.ip_address = 32'h0000_0000;
            5: item.ip_address = 32'hFFFF_FFFF;
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0: item.country_code = 16'd0;
            1: item.country_code = 16'(COUNTRY_COUNT - 1);
            2: item.country_code = 16'(COUNTRY_COUNT);
            3: item.country_code = 16'hFFFF;
            4: item.country_code = 16'($urandom_range(COUNTRY_COUNT, 65535));
            default: item.country_code = 16'($urandom_range(1, COUNTRY_COUNT - 1));
         endcase
      end else if (pick < 75) begin
         item.kind = OP_WRITE;
         case ($urandom_range(0, 5))
            0: item.range_high = item.range_low;
            1: item.range_high = item.range_low + 32'($urandom_range(0, 4095));
            2: ;
            3: item.range_low = 32'h0000_0000;
            4: item.range_high = 32'hFFFF_FFFF;
            default: item.range_high = item.range_low + ($urandom() >> $urandom_range(4, 31));
         endcase
      end else if (pick < 80) begin
         item.kind = OP_CLEAR;
      end else begin
         item.kind = OP_ALLOW;
         case ($urandom_range(0, 9))
            0: item.country_code = 16'd0;
            1: item.country_code = 16'($urandom_range(COUNTRY_COUNT, 65535));
            2: item.country_code = 16'(COUNTRY_COUNT - 1);
            default: item.country_code = 16'($urandom_range(1, COUNTRY_COUNT - 1));
         endcase
      end
      return item;
   endfunction

   task automatic send_request(req_type item);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 12);
      if (op_type'(item.kind) == OP_WRITE) begin
         span_lo[item.range_index] = item.range_low;
         span_hi[item.range_index] = item.range_high;
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data = item;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (verdicts_pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_register(logic [CSR_INDEX_W-1:0] index, int value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin : stimulus
      int     phase_count [8];
      bit     phase_en [8];
      req_type item;
      phase_count = '{64, 127, 1, 64, 0, -1, 63, -1};
      phase_en = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // filter off after reset
      send_request(compose(OP_CHECK, 32'h0000_0000, 6'd0, 32'd0, 32'd0, 16'hFFFF));
      send_request(compose(OP_CHECK, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0));
      send_request(compose(OP_WRITE, 32'd0, 6'd0, 32'h0A00_0000, 32'h0AFF_FFFF, 16'd0));
      send_request(compose(OP_WRITE, 32'd0, 6'd1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'd0));
      send_request(compose(OP_WRITE, 32'd0, 6'd2, 32'h0000_0000, 32'h0000_0000, 16'd0));
      send_request(compose(OP_WRITE, 32'd0, 6'd3, 32'hC0A8_0100, 32'hC0A8_00FF, 16'd0));
      send_request(compose(OP_WRITE, 32'd0, 6'd63, 32'hFFFF_FFFF, 32'h0000_0000, 16'd0));
      send_request(compose(OP_ALLOW, 32'd0, 6'd0, 32'd0, 32'd0, 16'(COUNTRY_COUNT - 1)));
      send_request(compose(OP_ALLOW, 32'd0, 6'd0, 32'd0, 32'd0, 16'd1));
      send_request(compose(OP_ALLOW, 32'd0, 6'd0, 32'd0, 32'd0, 16'(COUNTRY_COUNT)));
      send_request(compose(OP_ALLOW, 32'd0, 6'd0, 32'd0, 32'd0, 16'hFFFF));
      drain_results();
      program_register(CSR_FILTER_ENABLE, 1);
      program_register(CSR_RANGE_COUNT, 4);
      cur_count = 4;
      send_request(compose(OP_CHECK, 32'h1234_5678, 6'd0, 32'd0, 32'd0, 16'd0));
      send_request(compose(OP_CHECK, 32'h0A00_0000, 6'd0, 32'd0, 32'd0, 16'd7));
      send_request(compose(OP_CHECK, 32'h0AFF_FFFF, 6'd0, 32'd0, 32'd0, 16'd7));
      send_request(compose(OP_CHECK, 32'h0B00_0000, 6'd0, 32'd0, 32'd0, 16'd7));
      send_request(compose(OP_CHECK, 32'hFFFF_FFFF, 6'd0, 32'd0, 32'd0, 16'd300));
      send_request(compose(OP_CHECK, 32'h0000_0000, 6'd0, 32'd0, 32'd0, 16'hFFFF));
      send_request(compose(OP_CHECK, 32'hC0A8_0180, 6'd0, 32'd0, 32'd0, 16'(COUNTRY_COUNT)));
      send_request(compose(OP_CHECK, 32'h0102_0304, 6'd0, 32'd0, 32'd0, 16'(COUNTRY_COUNT - 1)));
      send_request(compose(OP_CHECK, 32'h0102_0304, 6'd0, 32'd0, 32'd0, 16'd1));
      send_request(compose(OP_CHECK, 32'h7FFF_FFFF, 6'd0, 32'd0, 32'd0, 16'hFFFF));
      send_request(compose(OP_CLEAR, 32'd0, 6'd0, 32'd0, 32'd0, 16'd0));
      send_request(compose(OP_CHECK, 32'h0102_0304, 6'd0, 32'd0, 32'd0, 16'(COUNTRY_COUNT - 1)));
      send_request(compose(OP_CHECK, 32'h0102_0304, 6'd0, 32'd0, 32'd0, 16'd2));
      drain_results();
      program_register(CSR_RANGE_COUNT, 0);
      cur_count = 0;
      send_request(compose(OP_CHECK, 32'h0A00_0001, 6'd0, 32'd0, 32'd0, 16'd9));

      // every range entry written before any wider range count
      for (int i = 0; i < MAX_RANGES; i++) begin
         item = random_item(60);
         item.range_index = 6'(i);
         send_request(item);
      end

      for (int p = 0; p < 8; p++) begin
         drain_results();
         cur_count = (phase_count[p] < 0) ? $urandom_range(0, 127) : phase_count[p];
         program_register(CSR_FILTER_ENABLE, phase_en[p]);
         program_register(CSR_RANGE_COUNT, cur_count);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            burst_mode = ((n / 40) % 3 == 1);
            if (p == 2 && n == 20)
               hold_rsp = 1'b1;
            send_request(random_item($urandom_range(0, 99)));
         end
      end

      drain_results();
      if (mismatch_count == 0 && verdicts_pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/ipraf_pkg.sv
hdl/ipraf_ram.sv
hdl/ipraf_front.sv
hdl/ipraf_back.sv
hdl/ip_range_and_country_allow_filter.sv
verif/ip_range_and_country_allow_filter_checker.sv
verif/ip_range_and_country_allow_filter_test.sv
